### rtl/hve_pkg.sv
// ----------------------------------------------------------------------------
// hve_pkg
// Shared types and constants for the mail header value extractor.
// ----------------------------------------------------------------------------
package hve_pkg;

  // Key store geometry
  localparam int KEY_LEN_W         = 5;
  localparam int MAX_KEY_BYTES_DEF = 24;

  // Front-to-back command queue
  localparam int CMD_QUEUE_DEPTH = 4;

  // Configuration register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 3'd3;

  // Character codes
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  typedef enum logic [2:0] {
    PH_MATCH    = 3'd0,
    PH_SKIPLINE = 3'd1,
    PH_LEAD     = 3'd2,
    PH_VALUE    = 3'd3,
    PH_DRAIN    = 3'd4
  } phase_t;

  // One front decision: up to three results, emitted in field order
  typedef struct packed {
    logic       sp;    // held space
    logic       by;    // value byte
    logic [7:0] data;
    logic       dn;    // done
    logic       fnd;
  } cmd_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + 8'd32;
    end
    return c;
  endfunction

endpackage

### rtl/mail_header_value_extractor.sv
// ----------------------------------------------------------------------------
// mail_header_value_extractor
// Streams a mail header and returns the cleaned value of one keyed field.
// ----------------------------------------------------------------------------
// The block takes one header byte per clock on push while full is low.
// A scanner compares each line start against the configured key (ASCII
// case-insensitive, followed by a colon), then follows the value across
// folded lines and decides per byte which results it causes: a held space,
// a cleaned byte and a done marker, at most three. These decisions go
// through a four-entry command queue to a serializer that presents one
// result at a time on the out_ ports while empty is low. Input runs at
// one byte per cycle as long as each byte yields at most one result and
// pop keeps up; a byte with two or three results holds the serializer
// until each is popped. The queue absorbs such bursts and output stalls.
// Bytes that yield nothing never enter the queue. Writes beyond index 3
// are ignored. Key registers are written via cfg_ (index 0..2 key bytes,
// 3 key length) only while idle: a user rule the block does not enforce.
// ----------------------------------------------------------------------------
module mail_header_value_extractor
  import hve_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic [7:0]            in_header_byte,
  input  logic                  in_final_byte,
  input  logic                  push,
  output logic                  full,
  // results
  output logic [7:0]            out_value_byte,
  output logic                  out_byte_present,
  output logic                  out_value_done,
  output logic                  out_key_found,
  output logic                  empty,
  input  logic                  pop,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [63:0]          key_low_r;
  logic [63:0]          key_mid_r;
  logic [63:0]          key_high_r;
  logic [KEY_LEN_W-1:0] key_len_r;

  logic accept;
  logic cmd_push;
  cmd_t cmd;
  cmd_t head_cmd;
  logic q_full, q_empty, q_pop;
  logic cfg_we;

  // Config is always accepted; one register per transaction
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_mid_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= KEY_LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        CFG_KEY_MID:  key_mid_r  <= cfg_data;
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        CFG_KEY_LEN:  key_len_r  <= cfg_data[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Stall input only when the queue cannot take another command
  assign full   = q_full;
  assign accept = push && !q_full;

  hve_front #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .header_byte (in_header_byte),
    .final_byte  (in_final_byte),
    .key_low     (key_low_r),
    .key_mid     (key_mid_r),
    .key_high    (key_high_r),
    .key_length  (key_len_r),
    .cmd_push    (cmd_push),
    .cmd         (cmd)
  );

  hve_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  hve_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_cmd     (head_cmd),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_empty    (empty),
    .out_pop      (pop),
    .value_byte   (out_value_byte),
    .byte_present (out_byte_present),
    .value_done   (out_value_done),
    .key_found    (out_key_found)
  );

endmodule

### rtl/hve_front.sv
// ----------------------------------------------------------------------------
// hve_front
// Per-byte scanner: key match, value tracking and cleaning decisions.
// ----------------------------------------------------------------------------
module hve_front
  import hve_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           header_byte,
  input  logic                 final_byte,
  input  logic [63:0]          key_low,
  input  logic [63:0]          key_mid,
  input  logic [63:0]          key_high,
  input  logic [KEY_LEN_W-1:0] key_length,
  output logic                 cmd_push,
  output cmd_t                 cmd
);

  localparam logic [KEY_LEN_W-1:0] KEY_MAX = KEY_LEN_W'(MAX_KEY_BYTES);

  phase_t               phase_r, phase_nxt;
  logic [KEY_LEN_W-1:0] mpos_r, mpos_nxt;
  logic                 an_r, an_nxt;   // after newline
  logic                 se_r, se_nxt;   // space emitted
  logic                 sp_r, sp_nxt;   // space pending
  logic                 vn_r, vn_nxt;   // value nonempty

  logic [KEY_LEN_W-1:0] klen;
  logic [63:0]          key_word;
  logic [7:0]           key_byte;
  logic                 is_ws;
  logic                 is_print;
  logic                 early_done;

  always_comb begin
    klen = (key_length > KEY_MAX) ? KEY_MAX : key_length;
    unique case (mpos_r[4:3])
      2'd0:    key_word = key_low;
      2'd1:    key_word = key_mid;
      default: key_word = key_high;
    endcase
    key_byte = key_word[{mpos_r[2:0], 3'b000} +: 8];
    is_ws    = (header_byte == CH_SPACE) || (header_byte == CH_TAB);
    is_print = (header_byte >= CH_BANG) && (header_byte <= CH_TILDE);
  end

  always_comb begin
    phase_nxt  = phase_r;
    mpos_nxt   = mpos_r;
    an_nxt     = an_r;
    se_nxt     = se_r;
    sp_nxt     = sp_r;
    vn_nxt     = vn_r;
    cmd        = '0;
    early_done = 1'b0;

    unique case (phase_r)
      PH_MATCH: begin
        if (klen == '0) begin
          // nothing can match
        end else if (mpos_r < klen) begin
          if (header_byte == CH_NEWLINE) begin
            mpos_nxt = '0;
          end else if (to_lower(header_byte) == to_lower(key_byte)) begin
            mpos_nxt = mpos_r + 1'b1;
          end else begin
            phase_nxt = PH_SKIPLINE;
          end
        end else begin
          if (header_byte == CH_COLON) begin
            phase_nxt = PH_LEAD;
          end else if (header_byte == CH_NEWLINE) begin
            mpos_nxt = '0;
          end else begin
            phase_nxt = PH_SKIPLINE;
          end
        end
      end
      PH_SKIPLINE: begin
        if (header_byte == CH_NEWLINE) begin
          phase_nxt = PH_MATCH;
          mpos_nxt  = '0;
        end
      end
      PH_LEAD, PH_VALUE: begin
        if (phase_r == PH_LEAD && is_ws) begin
          // leading blanks skipped
        end else begin
          phase_nxt = PH_VALUE;
          if (an_r && !is_ws) begin
            // unfolded line start ends the value
            early_done = 1'b1;
            cmd.dn     = 1'b1;
            cmd.fnd    = vn_r;
            phase_nxt  = PH_DRAIN;
          end else if (!an_r && header_byte == CH_NEWLINE) begin
            an_nxt = 1'b1;
          end else begin
            an_nxt = 1'b0;
            if (is_print) begin
              cmd.sp   = sp_r;
              cmd.by   = 1'b1;
              cmd.data = header_byte;
              sp_nxt   = 1'b0;
              se_nxt   = 1'b0;
              vn_nxt   = 1'b1;
            end else if (is_ws && !se_r) begin
              se_nxt = 1'b1;
              sp_nxt = 1'b1;
            end
          end
        end
      end
      PH_DRAIN: begin
      end
      default: begin
        phase_nxt = PH_MATCH;
        mpos_nxt  = '0;
        an_nxt    = 1'b0;
        se_nxt    = 1'b0;
        sp_nxt    = 1'b0;
        vn_nxt    = 1'b0;
      end
    endcase

    if (final_byte) begin
      if (!early_done && phase_nxt != PH_DRAIN) begin
        cmd.dn  = 1'b1;
        cmd.fnd = (phase_nxt == PH_LEAD || phase_nxt == PH_VALUE) && vn_nxt;
      end
      phase_nxt = PH_MATCH;
      mpos_nxt  = '0;
      an_nxt    = 1'b0;
      se_nxt    = 1'b0;
      sp_nxt    = 1'b0;
      vn_nxt    = 1'b0;
    end

    cmd_push = accept && (cmd.sp || cmd.by || cmd.dn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MATCH;
      mpos_r  <= '0;
      an_r    <= 1'b0;
      se_r    <= 1'b0;
      sp_r    <= 1'b0;
      vn_r    <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      mpos_r  <= mpos_nxt;
      an_r    <= an_nxt;
      se_r    <= se_nxt;
      sp_r    <= sp_nxt;
      vn_r    <= vn_nxt;
    end
  end

endmodule

### rtl/hve_cmd_fifo.sv
// ----------------------------------------------------------------------------
// hve_cmd_fifo
// Small command queue between scanner and result serializer.
// ----------------------------------------------------------------------------
module hve_cmd_fifo
  import hve_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMD_QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(CMD_QUEUE_DEPTH);

  cmd_t             mem [CMD_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full       = (count_r == DEPTH_CNT);
    empty      = (count_r == '0);
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
    head_cmd = mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/hve_back.sv
// ----------------------------------------------------------------------------
// hve_back
// Result serializer: splits a command into space, byte and done results.
// ----------------------------------------------------------------------------
module hve_back
  import hve_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head_cmd,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] value_byte,
  output logic       byte_present,
  output logic       value_done,
  output logic       key_found
);

  cmd_t cur_r, cur_nxt;
  logic cur_vld_r, cur_vld_nxt;
  logic last_one;
  logic take;

  always_comb begin
    out_empty = !cur_vld_r;
    if (cur_r.sp) begin
      value_byte   = CH_SPACE;
      byte_present = 1'b1;
      value_done   = 1'b0;
      key_found    = 1'b0;
    end else if (cur_r.by) begin
      value_byte   = cur_r.data;
      byte_present = 1'b1;
      value_done   = 1'b0;
      key_found    = 1'b0;
    end else begin
      value_byte   = 8'h00;
      byte_present = 1'b0;
      value_done   = 1'b1;
      key_found    = cur_r.fnd;
    end

    last_one = ({1'b0, cur_r.sp} + {1'b0, cur_r.by} + {1'b0, cur_r.dn}) == 2'd1;
    take     = out_pop && cur_vld_r;

    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    q_pop       = 1'b0;
    if (take) begin
      if (cur_r.sp) begin
        cur_nxt.sp = 1'b0;
      end else if (cur_r.by) begin
        cur_nxt.by = 1'b0;
      end else begin
        cur_nxt.dn = 1'b0;
      end
    end
    if (!cur_vld_r || (take && last_one)) begin
      q_pop       = !q_empty;
      cur_vld_nxt = !q_empty;
      cur_nxt     = head_cmd;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
    end
  end

endmodule

### tb/mail_header_value_extractor_tb.sv
// ----------------------------------------------------------------------------
// mail_header_value_extractor_tb
// Self-checking bench for the mail header value extractor.
// ----------------------------------------------------------------------------
// A directed table walks reset defaults, byte extremes, case folding, folded
// values, drain after the value ends, and key lengths zero, above the maximum
// and colon-as-last-byte. Random phases follow. Each phase sets a new key,
// then streams whole headers, usually with one keyed line and a random value.
// A local scanner predicts every result, and each popped result is compared
// with the oldest prediction. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module mail_header_value_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hve_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 3;
  localparam int SETTLE_CYCLES = 32;       // covers command queue + serializer
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 170;
  localparam int MAX_IDLE      = 13;
  localparam int MAX_PRINTS    = 100;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_present;
    logic       value_done;
    logic       key_found;
  } hdr_result_t;

  localparam hdr_result_t DONE_MISS = '{value_byte: 8'h00, byte_present: 1'b0,
                                        value_done: 1'b1, key_found: 1'b0};

  // Directed rows: a register write, or a byte whose results are either
  // typed in (none / done without a value) or taken from the scanner.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_QUIET,
    ROW_MISS,
    ROW_CALC
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [7:0]           hb;
    logic                 fin;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
  } dir_row_t;

  localparam int DIR_ROWS = 32;
  localparam logic [63:0] KEY_X_ID = 64'h0000_0000_6469_2d78;  // "x-id"

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // reset key is one NUL byte
    '{ROW_MISS,  "Z",        1'b1, CFG_KEY_LOW, 64'd0},
    '{ROW_QUIET, 8'h00,      1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_QUIET, CH_COLON,   1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_MISS,  8'hFF,      1'b1, CFG_KEY_LOW, 64'd0},
    // "x-id", header spelled in mixed case, folded value, drain
    '{ROW_CFG,   8'h00,      1'b0, CFG_KEY_LOW, KEY_X_ID},
    '{ROW_CFG,   8'h00,      1'b0, CFG_KEY_LEN, 64'd4},
    '{ROW_CALC,  "X",        1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  "-",        1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  "I",        1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  "D",        1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  CH_COLON,   1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  CH_SPACE,   1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  "a",        1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  CH_TAB,     1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  CH_NEWLINE, 1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  CH_TAB,     1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  "b",        1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  8'h7F,      1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  CH_TILDE,   1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  CH_NEWLINE, 1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  "Q",        1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_CALC,  "z",        1'b1, CFG_KEY_LOW, 64'd0},
    // zero-length key never matches
    '{ROW_CFG,   8'h00,      1'b0, CFG_KEY_LEN, 64'd0},
    '{ROW_MISS,  "a",        1'b1, CFG_KEY_LOW, 64'd0},
    // length above the maximum is clipped
    '{ROW_CFG,   8'h00,      1'b0, CFG_KEY_LEN, 64'd31},
    '{ROW_MISS,  "k",        1'b1, CFG_KEY_LOW, 64'd0},
    // header ends on the colon
    '{ROW_CFG,   8'h00,      1'b0, CFG_KEY_LEN, 64'd4},
    '{ROW_QUIET, "x",        1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_QUIET, "-",        1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_QUIET, "I",        1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_QUIET, "d",        1'b0, CFG_KEY_LOW, 64'd0},
    '{ROW_MISS,  CH_COLON,   1'b1, CFG_KEY_LOW, 64'd0}
  };

  // DUT ports; every input starts at a known value
  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic [7:0]            in_header_byte = 8'h00;
  logic                  in_final_byte  = 1'b0;
  logic                  push           = 1'b0;
  logic                  full;
  logic [7:0]            out_value_byte;
  logic                  out_byte_present;
  logic                  out_value_done;
  logic                  out_key_found;
  logic                  empty;
  logic                  pop            = 1'b0;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = CFG_KEY_LOW;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  mail_header_value_extractor i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_header_byte   (in_header_byte),
    .in_final_byte    (in_final_byte),
    .push             (push),
    .full             (full),
    .out_value_byte   (out_value_byte),
    .out_byte_present (out_byte_present),
    .out_value_done   (out_value_done),
    .out_key_found    (out_key_found),
    .empty            (empty),
    .pop              (pop),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Scanner mirror: key registers and per-search state
  // --------------------------------------------------------------------------
  logic [63:0] key_word [3] = '{64'd0, 64'd0, 64'd0};
  logic [4:0]  key_len_reg  = 5'd1;

  phase_t     scan_ph   = PH_MATCH;
  logic [4:0] key_pos   = '0;
  logic       nl_seen   = 1'b0;   // newline seen inside the value
  logic       sp_out    = 1'b0;   // current blank run already counted
  logic       sp_hold   = 1'b0;   // one space waiting for a printable byte
  logic       have_text = 1'b0;

  hdr_result_t value_q [$];       // predicted results, oldest first
  logic [7:0]  hdr_bytes [$];     // header under construction

  int unsigned errors     = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned pop_hold   = 0;
  bit          push_eager = 1'b0;
  bit          pop_eager  = 1'b0;

  function automatic logic [7:0] key_char(input int i);
    return key_word[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic void put_result(ref hdr_result_t q [$], input logic [7:0] b,
                                     input logic pres, input logic dn,
                                     input logic fnd);
    q.push_back('{value_byte: b, byte_present: pres, value_done: dn, key_found: fnd});
  endfunction

  function automatic void clear_search();
    scan_ph   = PH_MATCH;
    key_pos   = '0;
    nl_seen   = 1'b0;
    sp_out    = 1'b0;
    sp_hold   = 1'b0;
    have_text = 1'b0;
  endfunction

  // Printable bytes pass, a blank run collapses to one held space.
  function automatic void take_value_char(input logic [7:0] c, ref hdr_result_t q [$]);
    if (c >= CH_BANG && c <= CH_TILDE) begin
      if (sp_hold) put_result(q, CH_SPACE, 1'b1, 1'b0, 1'b0);
      put_result(q, c, 1'b1, 1'b0, 1'b0);
      sp_hold   = 1'b0;
      sp_out    = 1'b0;
      have_text = 1'b1;
    end else if (is_blank(c) && !sp_out) begin
      sp_out  = 1'b1;
      sp_hold = 1'b1;
    end
  endfunction

  function automatic void extract_step(input logic [7:0] c, input logic fin,
                                       ref hdr_result_t q [$]);
    int klen;
    klen = (key_len_reg > MAX_KEY_BYTES_DEF) ? MAX_KEY_BYTES_DEF : key_len_reg;
    case (scan_ph)
      PH_MATCH: begin
        if (klen == 0) begin
          // nothing can match
        end else if (key_pos < klen) begin
          if (c == CH_NEWLINE) key_pos = '0;
          else if (fold_case(c) == fold_case(key_char(key_pos))) key_pos++;
          else scan_ph = PH_SKIPLINE;
        end else begin
          if (c == CH_COLON) scan_ph = PH_LEAD;
          else if (c == CH_NEWLINE) key_pos = '0;
          else scan_ph = PH_SKIPLINE;
        end
      end
      PH_SKIPLINE: begin
        if (c == CH_NEWLINE) begin
          scan_ph = PH_MATCH;
          key_pos = '0;
        end
      end
      PH_LEAD, PH_VALUE: begin
        if (!(scan_ph == PH_LEAD && is_blank(c))) begin
          scan_ph = PH_VALUE;
          if (nl_seen) begin
            // unfolded newline: value is over on this byte
            if (!is_blank(c)) begin
              put_result(q, 8'h00, 1'b0, 1'b1, have_text);
              if (fin) clear_search();
              else scan_ph = PH_DRAIN;
              return;
            end
            nl_seen = 1'b0;
            take_value_char(c, q);
          end else if (c == CH_NEWLINE) begin
            nl_seen = 1'b1;
          end else begin
            take_value_char(c, q);
          end
        end
      end
      PH_DRAIN: begin
        // ignore until the last header byte
      end
      default: clear_search();
    endcase

    if (fin) begin
      if (scan_ph != PH_DRAIN)
        put_result(q, 8'h00, 1'b0, 1'b1,
                   (scan_ph == PH_LEAD || scan_ph == PH_VALUE) && have_text);
      clear_search();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Result side pops at random; pop changes only on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_hold != 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hdr_result_t got, want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst_n && pop && !empty) begin
      got = {out_value_byte, out_byte_present, out_value_done, out_key_found};
      if (value_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%02h present=%0b done=%0b found=%0b",
                                  got.value_byte, got.byte_present, got.value_done,
                                  got.key_found));
      end else begin
        want = value_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf(
            "got byte=%02h present=%0b done=%0b found=%0b, want %02h/%0b/%0b/%0b",
            got.value_byte, got.byte_present, got.value_done, got.key_found,
            want.value_byte, want.byte_present, want.value_done, want.key_found));
      end
      pop_hold = pop_eager ? 0 : $urandom_range(0, MAX_IDLE);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One byte transaction; results are predicted at the accepting edge.
  task automatic send_byte(input logic [7:0] c, input logic fin, input row_kind_t kind);
    hdr_result_t calc [$];
    int gap;
    gap = push_eager ? 0 : $urandom_range(0, MAX_IDLE);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push           <= 1'b1;
    in_header_byte <= c;
    in_final_byte  <= fin;
    do @(posedge clk); while (full);
    extract_step(c, fin, calc);
    case (kind)
      ROW_QUIET: ;
      ROW_MISS:  value_q.push_back(DONE_MISS);
      default:   foreach (calc[i]) value_q.push_back(calc[i]);
    endcase
  endtask

  // Drops push and waits until every predicted result has been popped,
  // plus slack for bytes that cause nothing but may still be in flight.
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (value_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KEY_LOW:  key_word[0] = d;
      CFG_KEY_MID:  key_word[1] = d;
      CFG_KEY_HIGH: key_word[2] = d;
      CFG_KEY_LEN:  key_len_reg = d[4:0];
      default: ;    // unmapped index, ignored
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_key_char();
    case ($urandom_range(0, 15))
      0:       return 8'($urandom_range(0, 255));
      1:       return CH_NEWLINE;   // can never match a header byte
      default: return 8'($urandom_range(CH_BANG, CH_TILDE));
    endcase
  endfunction

  // Builds a header of 1..3 lines; usually one starts with the key
  // (random case, rarely corrupted), followed by a noisy, folded value.
  task automatic build_header();
    int lines, hit, n, klen, keep;
    logic [7:0] c;
    hdr_bytes.delete();
    lines = $urandom_range(1, 3);
    hit   = $urandom_range(0, lines);   // hit == lines: no keyed line
    klen  = (key_len_reg > MAX_KEY_BYTES_DEF) ? MAX_KEY_BYTES_DEF : key_len_reg;
    for (int ln = 0; ln < lines; ln++) begin
      if (ln == hit) begin
        for (int i = 0; i < klen; i++) begin
          c = key_char(i);
          if ($urandom_range(0, 11) == 0) c = 8'($urandom_range(0, 255));
          else if (fold_case(c | 8'h20) != (c | 8'h20) || ((c | 8'h20) >= "a" &&
                   (c | 8'h20) <= "z" && $urandom_range(0, 1))) c ^= 8'h20;
          hdr_bytes.push_back(c);
        end
        if ($urandom_range(0, 9) != 0) hdr_bytes.push_back(CH_COLON);
        n = $urandom_range(0, 10);
      end else begin
        n = $urandom_range(0, 8);
      end
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: hdr_bytes.push_back(8'($urandom_range(CH_BANG, CH_TILDE)));
          4, 5:       hdr_bytes.push_back(CH_SPACE);
          6:          hdr_bytes.push_back(CH_TAB);
          7:          hdr_bytes.push_back(8'($urandom_range(0, 255)));
          8: begin    // folded continuation
            hdr_bytes.push_back(CH_NEWLINE);
            hdr_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
          end
          default: begin  // line break that ends the value
            hdr_bytes.push_back(CH_NEWLINE);
            hdr_bytes.push_back(8'($urandom_range(CH_BANG, CH_TILDE)));
          end
        endcase
      end
      if (ln < lines - 1 || $urandom_range(0, 1)) hdr_bytes.push_back(CH_NEWLINE);
    end
    // truncated headers end inside the key, on the colon or mid value
    if ($urandom_range(0, 5) == 0 && hdr_bytes.size() > 1) begin
      keep = $urandom_range(1, hdr_bytes.size());
      while (hdr_bytes.size() > keep) void'(hdr_bytes.pop_back());
    end
    if (hdr_bytes.size() == 0) hdr_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int random_sent;
    int klen_pick;
    logic [63:0] kw [3];
    random_sent = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        send_byte(DIRECTED[r].hb, DIRECTED[r].fin, DIRECTED[r].kind);
      end
    end

    // random phases: new key, then a few whole headers
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      for (int i = 0; i < 24; i++) kw[i / 8][(i % 8) * 8 +: 8] = rand_key_char();
      case ($urandom_range(0, 9))
        0:       klen_pick = 0;
        1:       klen_pick = MAX_KEY_BYTES_DEF;
        2:       klen_pick = 31;
        3:       klen_pick = 1;
        4, 5:    klen_pick = $urandom_range(5, 12);
        default: klen_pick = $urandom_range(1, 4);
      endcase
      write_reg(CFG_KEY_LOW,  kw[0]);
      write_reg(CFG_KEY_MID,  kw[1]);
      write_reg(CFG_KEY_HIGH, kw[2]);
      write_reg(CFG_KEY_LEN,  64'(klen_pick));
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_KEY_LEN + CFG_IDX_W'($urandom_range(1, 4)), {$urandom, $urandom});
      push_eager = ($urandom_range(0, 3) == 0);
      pop_eager  = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        build_header();
        foreach (hdr_bytes[i])
          send_byte(hdr_bytes[i], i == hdr_bytes.size() - 1, ROW_CALC);
        random_sent += hdr_bytes.size();
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
